[design/cfm_pkg.sv]
package cfm_pkg;

    // Field widths
    localparam int REQ_W     = 2;
    localparam int STAT_W    = 2;
    localparam int COORD_W   = 32;
    localparam int MEAN_W    = 40;
    localparam int CNT_OUT_W = 5;
    localparam int FRAC_W    = 8;
    localparam int NAX       = 3;

    localparam int DEF_QUEUE_DEPTH = 16;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MEAN = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic load;       // latch the incoming word
        logic push;       // write the store, advance tail, add to sums
        logic pop_rd;     // read the store at head
        logic pop;        // advance head, subtract from sums
        logic div_start;  // load the three dividers
        logic div_step;   // one quotient bit per lane
        logic mean;       // post the means
        logic flag;       // post a result without touching the queue
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             empty;
        logic             full;
        logic             out_free;
        logic             div_done;
    } t_sts;

endpackage

[design/coordinate_fifo_with_mean.sv]
// Channel   Direction  Handshake                Payload
// request   in         i_in_valid / o_in_stall  i_req_type, i_coord_x/y/z
// result    out        o_out_valid / i_out_stall o_status, o_popped_x/y/z,
//                                                o_mean_x/y/z, o_entry_count
//
// One word is worked on at a time: push, unknown and flagged requests go
// straight to the result register; a pop first does a registered store read;
// a mean runs the three restoring dividers, which produce one quotient bit per
// cycle in parallel.
// Reset is synchronous and active low; it empties the queue and zeroes the
// sums. The store itself is not cleared: only occupied entries are read.
// A stalled result sits in the output register while the next word is taken
// and worked on; only its final write-back waits for the register to free up.
module coordinate_fifo_with_mean import cfm_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [REQ_W-1:0]            i_req_type,
    input  logic signed [COORD_W-1:0]   i_coord_x,
    input  logic signed [COORD_W-1:0]   i_coord_y,
    input  logic signed [COORD_W-1:0]   i_coord_z,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [STAT_W-1:0]           o_status,
    output logic signed [COORD_W-1:0]   o_popped_x,
    output logic signed [COORD_W-1:0]   o_popped_y,
    output logic signed [COORD_W-1:0]   o_popped_z,
    output logic signed [MEAN_W-1:0]    o_mean_x,
    output logic signed [MEAN_W-1:0]    o_mean_y,
    output logic signed [MEAN_W-1:0]    o_mean_z,
    output logic [CNT_OUT_W-1:0]        o_entry_count
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer: take a word, run its request, hold until the result
    // register can take the answer.
    cfm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Store, pointers, running sums, dividers and the result register.
    cfm_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_req_type    (i_req_type),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_popped_x    (o_popped_x),
        .o_popped_y    (o_popped_y),
        .o_popped_z    (o_popped_z),
        .o_mean_x      (o_mean_x),
        .o_mean_y      (o_mean_y),
        .o_mean_z      (o_mean_z),
        .o_entry_count (o_entry_count)
    );

endmodule

[design/cfm_ram.sv]
module cfm_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/cfm_ctrl.sv]
module cfm_ctrl import cfm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_POP_WB = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_cmd       w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_sts.req)
                    REQ_PUSH: begin
                        if (i_sts.out_free) begin
                            w_cmd.push = !i_sts.full;
                            w_cmd.flag = i_sts.full;
                            n_state    = S_IDLE;
                        end
                    end
                    REQ_POP: begin
                        if (i_sts.empty) begin
                            if (i_sts.out_free) begin
                                w_cmd.flag = 1'b1;
                                n_state    = S_IDLE;
                            end
                        end else begin
                            w_cmd.pop_rd = 1'b1;
                            n_state      = S_POP_WB;
                        end
                    end
                    REQ_MEAN: begin
                        if (i_sts.empty) begin
                            if (i_sts.out_free) begin
                                w_cmd.flag = 1'b1;
                                n_state    = S_IDLE;
                            end
                        end else begin
                            w_cmd.div_start = 1'b1;
                            n_state         = S_DIV;
                        end
                    end
                    default: begin
                        if (i_sts.out_free) begin
                            w_cmd.flag = 1'b1;
                            n_state    = S_IDLE;
                        end
                    end
                endcase
            end
            S_POP_WB: begin
                if (i_sts.out_free) begin
                    w_cmd.pop = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_DIV: begin
                if (!i_sts.div_done) begin
                    w_cmd.div_step = 1'b1;
                end else if (i_sts.out_free) begin
                    w_cmd.mean = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = w_cmd;
    // hold off words while busy and while reset is asserted
    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;

endmodule

[design/cfm_dp.sv]
module cfm_dp import cfm_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    output t_sts                        o_sts,
    input  logic [REQ_W-1:0]            i_req_type,
    input  logic signed [COORD_W-1:0]   i_coord_x,
    input  logic signed [COORD_W-1:0]   i_coord_y,
    input  logic signed [COORD_W-1:0]   i_coord_z,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic [STAT_W-1:0]           o_status,
    output logic signed [COORD_W-1:0]   o_popped_x,
    output logic signed [COORD_W-1:0]   o_popped_y,
    output logic signed [COORD_W-1:0]   o_popped_z,
    output logic signed [MEAN_W-1:0]    o_mean_x,
    output logic signed [MEAN_W-1:0]    o_mean_y,
    output logic signed [MEAN_W-1:0]    o_mean_z,
    output logic [CNT_OUT_W-1:0]        o_entry_count
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = COORD_W + AW;
    localparam int ND = SW + FRAC_W;
    localparam int KW = $clog2(ND + 1);
    localparam int RW = NAX * COORD_W;

    logic [REQ_W-1:0]   r_req;
    logic [AW-1:0]      r_head;
    logic [AW-1:0]      r_tail;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [KW-1:0]      r_div_cnt;
    logic               r_out_valid;
    logic [STAT_W-1:0]  r_status;
    logic [CNT_OUT_W-1:0] r_cnt_out;

    logic                      w_commit;
    logic                      w_out_free;
    logic [STAT_W-1:0]         w_flag_stat;
    logic [CNT_OUT_W+CW-1:0]   w_cnt_ext;
    logic [RW-1:0]             w_ram_rdata;
    logic [RW-1:0]             w_ram_wdata;

    logic signed [COORD_W-1:0] w_in      [NAX];
    logic signed [COORD_W-1:0] w_crd     [NAX];
    logic signed [COORD_W-1:0] w_pop_out [NAX];
    logic signed [MEAN_W-1:0]  w_mean_out[NAX];

    assign w_in[0] = i_coord_x;
    assign w_in[1] = i_coord_y;
    assign w_in[2] = i_coord_z;

    assign w_commit   = i_cmd.push | i_cmd.pop | i_cmd.mean | i_cmd.flag;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        case (r_req)
            REQ_PUSH: w_flag_stat = ST_FULL;
            REQ_POP:  w_flag_stat = ST_EMPTY;
            REQ_MEAN: w_flag_stat = ST_EMPTY;
            default:  w_flag_stat = ST_OK;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.push) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    assign w_cnt_ext = {{CNT_OUT_W{1'b0}}, n_count};

    // Queue pointers, fill count, divider count, result handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_tail <= (r_tail == AW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + AW'(1);
            end
            if (i_cmd.pop) begin
                r_head <= (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + AW'(1);
            end
            r_count <= n_count;
            if (i_cmd.div_start) begin
                r_div_cnt <= KW'(ND);
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt - KW'(1);
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req_type;
        end
        if (w_commit) begin
            r_status  <= i_cmd.flag ? w_flag_stat : ST_OK;
            r_cnt_out <= w_cnt_ext[CNT_OUT_W-1:0];
        end
    end

    // One lane per axis: latched coordinate, running sum, restoring divider, result registers
    for (genvar l = 0; l < NAX; l++) begin : g_lane
        logic signed [COORD_W-1:0] r_crd;
        logic signed [SW-1:0]      r_sum;
        logic [CW-1:0]             r_rem;
        logic [ND-1:0]             r_quo;
        logic                      r_neg;
        logic signed [COORD_W-1:0] r_pop;
        logic signed [MEAN_W-1:0]  r_mean;

        logic signed [COORD_W-1:0] w_pop;
        logic [SW-1:0]             w_mag;
        logic [CW:0]               w_sh;
        logic [CW:0]               w_diff;
        logic                      w_ge;
        logic [MEAN_W-1:0]         w_qm;
        logic [MEAN_W-1:0]         w_mean;

        assign w_pop  = w_ram_rdata[(NAX-l)*COORD_W-1 -: COORD_W];
        assign w_mag  = r_sum[SW-1] ? (~r_sum + SW'(1)) : r_sum;
        assign w_sh   = {r_rem, r_quo[ND-1]};
        assign w_ge   = (w_sh >= {1'b0, r_count});
        assign w_diff = w_sh - {1'b0, r_count};
        assign w_qm   = r_quo[MEAN_W-1:0];
        assign w_mean = r_neg ? (~w_qm + MEAN_W'(1)) : w_qm;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sum <= '0;
            end else if (i_cmd.push) begin
                r_sum <= r_sum + SW'(r_crd);
            end else if (i_cmd.pop) begin
                r_sum <= r_sum - SW'(w_pop);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.load) begin
                r_crd <= w_in[l];
            end
            if (i_cmd.div_start) begin
                r_neg <= r_sum[SW-1];
                r_quo <= {w_mag, {FRAC_W{1'b0}}};
                r_rem <= '0;
            end else if (i_cmd.div_step) begin
                r_rem <= w_ge ? w_diff[CW-1:0] : w_sh[CW-1:0];
                r_quo <= {r_quo[ND-2:0], w_ge};
            end
            if (w_commit) begin
                r_pop  <= i_cmd.pop ? w_pop : '0;
                r_mean <= i_cmd.mean ? w_mean : '0;
            end
        end

        assign w_crd[l]      = r_crd;
        assign w_pop_out[l]  = r_pop;
        assign w_mean_out[l] = r_mean;
    end

    assign w_ram_wdata = {w_crd[0], w_crd[1], w_crd[2]};

    cfm_ram #(
        .WIDTH (RW),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_tail),
        .i_wdata (w_ram_wdata),
        .i_re    (i_cmd.pop_rd),
        .i_raddr (r_head),
        .o_rdata (w_ram_rdata)
    );

    assign o_sts.req      = r_req;
    assign o_sts.empty    = (r_count == '0);
    assign o_sts.full     = (r_count == CW'(QUEUE_DEPTH));
    assign o_sts.out_free = w_out_free;
    assign o_sts.div_done = (r_div_cnt == '0);

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_popped_x    = w_pop_out[0];
    assign o_popped_y    = w_pop_out[1];
    assign o_popped_z    = w_pop_out[2];
    assign o_mean_x      = w_mean_out[0];
    assign o_mean_y      = w_mean_out[1];
    assign o_mean_z      = w_mean_out[2];
    assign o_entry_count = r_cnt_out;

endmodule

[tb/coordinate_fifo_with_mean_tb.sv]
module coordinate_fifo_with_mean_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cfm_pkg::*;

    localparam int QUEUE_DEPTH     = DEF_QUEUE_DEPTH;
    localparam int WATCHDOG_LIMIT  = 4000;  // cycles with no word moving on either side
    localparam int DRAIN_CYCLES    = 60;    // the longest word is a mean
    localparam int RANDOM_WORDS    = 309;   // per idling phase

    // Request code that the block must ignore
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [REQ_W-1:0]          req;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_coord_word;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_triple;

    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic signed [COORD_W-1:0] popped_x;
        logic signed [COORD_W-1:0] popped_y;
        logic signed [COORD_W-1:0] popped_z;
        logic signed [MEAN_W-1:0]  mean_x;
        logic signed [MEAN_W-1:0]  mean_y;
        logic signed [MEAN_W-1:0]  mean_z;
        logic [CNT_OUT_W-1:0]      entry_count;
    } t_fifo_result;

    // ------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        i_in_valid    = 1'b0;
    logic                        o_in_stall;
    logic [REQ_W-1:0]            i_req_type    = '0;
    logic signed [COORD_W-1:0]   i_coord_x     = '0;
    logic signed [COORD_W-1:0]   i_coord_y     = '0;
    logic signed [COORD_W-1:0]   i_coord_z     = '0;
    logic                        o_out_valid;
    logic                        i_out_stall   = 1'b0;
    logic [STAT_W-1:0]           o_status;
    logic signed [COORD_W-1:0]   o_popped_x;
    logic signed [COORD_W-1:0]   o_popped_y;
    logic signed [COORD_W-1:0]   o_popped_z;
    logic signed [MEAN_W-1:0]    o_mean_x;
    logic signed [MEAN_W-1:0]    o_mean_y;
    logic signed [MEAN_W-1:0]    o_mean_z;
    logic [CNT_OUT_W-1:0]        o_entry_count;

    coordinate_fifo_with_mean #(
        .QUEUE_DEPTH   (QUEUE_DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_popped_x    (o_popped_x),
        .o_popped_y    (o_popped_y),
        .o_popped_z    (o_popped_z),
        .o_mean_x      (o_mean_x),
        .o_mean_y      (o_mean_y),
        .o_mean_z      (o_mean_z),
        .o_entry_count (o_entry_count)
    );

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    t_coord_word   words_pending[$];   // requests not yet on the bus
    t_fifo_result  results_due[$];     // predicted results, oldest first
    t_coord_word   word_on_bus;        // request currently presented
    t_fifo_result  oldest_due;

    // Predictor copy of the queue and its running sums
    t_triple       stored_triples[$];
    longint        axis_sum_x;
    longint        axis_sum_y;
    longint        axis_sum_z;

    int            send_idle_pct = 27;
    int            recv_idle_pct = 72;
    int            mismatches    = 0;
    int            quiet_cycles  = 0;

    // What the run reached, for the summary
    int            n_push_ok, n_push_full, n_pop_ok, n_pop_empty;
    int            n_mean_ok, n_mean_empty, n_unknown, n_results;
    int            deepest;

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Predictor: apply one accepted request to the queue copy and
    // return the result word the block must produce for it.
    // ------------------------------------------------------------------
    function automatic t_fifo_result fifo_mean_step(t_coord_word w);
        t_fifo_result r;
        t_triple      t;
        longint       cnt;
        r   = '0;
        cnt = stored_triples.size();
        case (w.req)
            REQ_PUSH: begin
                if (cnt >= QUEUE_DEPTH) begin
                    // drop the triple, leave the queue as it is
                    r.status = ST_FULL;
                    n_push_full++;
                end else begin
                    t.x = w.x;
                    t.y = w.y;
                    t.z = w.z;
                    stored_triples.push_back(t);
                    axis_sum_x += longint'($signed(w.x));
                    axis_sum_y += longint'($signed(w.y));
                    axis_sum_z += longint'($signed(w.z));
                    n_push_ok++;
                end
            end
            REQ_POP: begin
                if (cnt == 0) begin
                    r.status = ST_EMPTY;
                    n_pop_empty++;
                end else begin
                    t = stored_triples.pop_front();
                    r.popped_x = t.x;
                    r.popped_y = t.y;
                    r.popped_z = t.z;
                    axis_sum_x -= longint'($signed(t.x));
                    axis_sum_y -= longint'($signed(t.y));
                    axis_sum_z -= longint'($signed(t.z));
                    n_pop_ok++;
                end
            end
            REQ_MEAN: begin
                if (cnt == 0) begin
                    r.status = ST_EMPTY;
                    n_mean_empty++;
                end else begin
                    // scale to Q8 first, then divide; SV division truncates toward zero
                    r.mean_x = MEAN_W'((axis_sum_x * 256) / cnt);
                    r.mean_y = MEAN_W'((axis_sum_y * 256) / cnt);
                    r.mean_z = MEAN_W'((axis_sum_z * 256) / cnt);
                    n_mean_ok++;
                end
            end
            default: begin
                n_unknown++;
            end
        endcase
        r.entry_count = CNT_OUT_W'(stored_triples.size());
        if (stored_triples.size() > deepest)
            deepest = stored_triples.size();
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: present queued requests, hold a stalled word unchanged,
    // idle at random at the current sender rate.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            // Predict as soon as the word is taken
            if (i_in_valid && !o_in_stall)
                results_due.push_back(fifo_mean_step(word_on_bus));
            // Advance only when the bus is free or the word just moved
            if (!i_in_valid || !o_in_stall) begin
                if (words_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    word_on_bus = words_pending.pop_front();
                    i_req_type  <= word_on_bus.req;
                    i_coord_x   <= word_on_bus.x;
                    i_coord_y   <= word_on_bus.y;
                    i_coord_z   <= word_on_bus.z;
                    i_in_valid  <= 1'b1;
                end else begin
                    i_in_valid  <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each taken result word against the oldest
    // prediction, stall at random at the current receiver rate.
    // ------------------------------------------------------------------
    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                n_results++;
                if (results_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, %s %0d count %0d",
                             $time, "actual status", o_status, o_entry_count);
                end else begin
                    oldest_due = results_due.pop_front();
                    check_field("status", oldest_due.status, o_status);
                    check_field("popped_x", oldest_due.popped_x, o_popped_x);
                    check_field("popped_y", oldest_due.popped_y, o_popped_y);
                    check_field("popped_z", oldest_due.popped_z, o_popped_z);
                    check_field("mean_x", oldest_due.mean_x, o_mean_x);
                    check_field("mean_y", oldest_due.mean_y, o_mean_y);
                    check_field("mean_z", oldest_due.mean_z, o_mean_z);
                    check_field("entry_count", oldest_due.entry_count, o_entry_count);
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no word moves for too long
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d quiet cycles, %0d results still due",
                     quiet_cycles, results_due.size());
            $display("FAIL coordinate_fifo_with_mean");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_word(logic [REQ_W-1:0] req, logic signed [COORD_W-1:0] x,
                              logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z);
        t_coord_word w;
        w.req = req;
        w.x   = x;
        w.y   = y;
        w.z   = z;
        words_pending.push_back(w);
    endtask

    // Mix extremes, small values near zero and full-range noise
    function automatic logic signed [COORD_W-1:0] pick_coord();
        case ($urandom_range(9))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return '0;
            3:       return -1;
            4:       return $signed($urandom_range(200)) - 100;
            default: return $urandom;
        endcase
    endfunction

    // Random bursts that lean toward filling, draining or holding the
    // queue, so that full, empty and pointer wrap all come up often
    task automatic queue_random_words(int count);
        int bias;
        int left;
        int sel;
        int push_pct;
        int pop_pct;
        left = 0;
        bias = 0;
        repeat (count) begin
            if (left == 0) begin
                bias = $urandom_range(2);
                left = $urandom_range(40, 8);
            end
            left--;
            push_pct = (bias == 0) ? 65 : (bias == 1) ? 20 : 40;
            pop_pct  = (bias == 0) ? 85 : (bias == 1) ? 80 : 75;
            sel      = $urandom_range(99);
            if (sel < push_pct)
                queue_word(REQ_PUSH, pick_coord(), pick_coord(), pick_coord());
            else if (sel < pop_pct)
                queue_word(REQ_POP, $urandom, $urandom, $urandom);
            else if (sel < 97)
                queue_word(REQ_MEAN, $urandom, $urandom, $urandom);
            else
                queue_word(REQ_UNKNOWN, $urandom, $urandom, $urandom);
        end
    endtask

    // Hold the sender until every queued word is taken and every result is back
    task automatic wait_all_done();
        while (words_pending.size() != 0 || i_in_valid || results_due.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        axis_sum_x = 0;
        axis_sum_y = 0;
        axis_sum_z = 0;
        n_push_ok = 0; n_push_full = 0; n_pop_ok = 0; n_pop_empty = 0;
        n_mean_ok = 0; n_mean_empty = 0; n_unknown = 0; n_results = 0;
        deepest = 0;

        // Empty queue: mean, pop and an unknown request
        queue_word(REQ_MEAN, $urandom, $urandom, $urandom);
        queue_word(REQ_POP, $urandom, $urandom, $urandom);
        queue_word(REQ_UNKNOWN, $urandom, $urandom, $urandom);
        // Fill with extremes: x sums to the most negative mean, y to the
        // most positive, z alternates so its mean lands just below zero
        for (int i = 0; i < QUEUE_DEPTH; i++)
            queue_word(REQ_PUSH, COORD_MIN, COORD_MAX, (i % 2) ? COORD_MAX : COORD_MIN);
        // Full queue: dropped push, mean over every entry, ignored request
        queue_word(REQ_PUSH, pick_coord(), pick_coord(), pick_coord());
        queue_word(REQ_MEAN, $urandom, $urandom, $urandom);
        queue_word(REQ_UNKNOWN, $urandom, $urandom, $urandom);
        // Pop the oldest, then a mean over one entry fewer
        queue_word(REQ_POP, $urandom, $urandom, $urandom);
        queue_word(REQ_MEAN, $urandom, $urandom, $urandom);

        // Phase one: sender idles lightly, receiver stalls heavily
        queue_random_words(RANDOM_WORDS);
        wait_all_done();

        // Phase two: the other way round
        send_idle_pct = 72;
        recv_idle_pct = 27;
        queue_random_words(RANDOM_WORDS);
        wait_all_done();

        // Phase three: back to back on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_words(RANDOM_WORDS - 1);
        wait_all_done();

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d results: %0d pushes, %0d dropped on full, %0d pops,",
                 n_results, n_push_ok, n_push_full, n_pop_ok);
        $display("  %0d pops on empty, %0d means, %0d means on empty, %0d ignored, depth %0d",
                 n_pop_empty, n_mean_ok, n_mean_empty, n_unknown, deepest);
        if (mismatches == 0)
            $display("PASS coordinate_fifo_with_mean");
        else
            $display("FAIL coordinate_fifo_with_mean");
        $finish;
    end

endmodule

[sim.f]
design/cfm_pkg.sv
design/cfm_ram.sv
design/cfm_ctrl.sv
design/cfm_dp.sv
design/coordinate_fifo_with_mean.sv
tb/coordinate_fifo_with_mean_tb.sv
